### design/usvt_pkg.sv
package usvt_pkg;

   // default table depth
   localparam int ENTRIES_DEF = 16;

   // fixed field widths
   localparam int VALUE_W  = 32;
   localparam int ACTION_W = 3;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   // stream payload widths, zero filled to whole bytes
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT    = 3'd0,
      ACT_REM_VALUE = 3'd1,
      ACT_REM_SLOT  = 3'd2,
      ACT_REPLACE   = 3'd3,
      ACT_SEARCH    = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_DUP      = 3'd3,
      ST_NOTFOUND = 3'd4,
      ST_BADSLOT  = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_SCAN,
      FSM_DECIDE
   } fsm_type;

endpackage

### design/unique_value_set_table_top.sv
// unique value set table: a table of ENTRIES signed 32-bit values, 0 meaning an
// empty slot, with no value held twice, plus a count of occupied slots.
// requests arrive on the req_ stream: tuser carries the action (insert, remove
// value, remove slot, replace, search), tdata the key, new value and slot.
// every request gives exactly one transfer on the rsp_ stream carrying the
// status, the slot found by a successful search and the count afterwards.
// for each request the single read port of the value memory is swept over every
// slot, one slot a cycle, with the read data registered; then the decide step
// settles the outcome and, once the output register is free, registers the
// result and writes the memory back. one request is worked on at a time; the
// next is accepted in the cycle after the previous result is registered, even
// while that result still waits for the receiver.
// after reset the memory is swept to zero with req_tready low.
// a stalled receiver holds the result steady; a second finished result waits
// in the decide step until the output register is free.
module unique_value_set_table_top #(
   parameter int ENTRIES = usvt_pkg::ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: key_value[31:0], new_value[63:32], slot_index[67:64], zero [71:68]
   input  logic [usvt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: action[2:0]
   input  logic [usvt_pkg::ACTION_W-1:0]     req_tuser,
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: status[2:0], found_slot[6:3], stored_count[11:7], zero [15:12]
   output logic [usvt_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   // value memory, one read and one write port
   logic [usvt_pkg::VALUE_W-1:0] mem [ENTRIES];
   logic [usvt_pkg::VALUE_W-1:0] rd_data_ff;
   logic [AW-1:0]                rd_addr;
   logic                         mem_we;
   logic [AW-1:0]                mem_wa;
   logic [usvt_pkg::VALUE_W-1:0] mem_wd;

   usvt_pkg::fsm_type state_ff, state_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [CW-1:0]     fc_ff, fc_in;
   logic [AW-1:0]     rd_idx_ff;

   // request held for the whole scan
   logic [usvt_pkg::ACTION_W-1:0]     action_ff;
   logic signed [usvt_pkg::VALUE_W-1:0] key_ff;
   logic signed [usvt_pkg::VALUE_W-1:0] nv_ff;
   logic [usvt_pkg::SLOT_W-1:0]       slot_ff;

   // scan findings
   logic          key_hit_ff, nv_hit_ff, zero_hit_ff, slot_nz_ff;
   logic [AW-1:0] key_idx_ff, zero_idx_ff;

   // result register
   logic                          rsp_valid_ff;
   logic [usvt_pkg::STATUS_W-1:0] status_ff;
   logic [usvt_pkg::SLOT_W-1:0]   found_ff;
   logic [usvt_pkg::COUNT_W-1:0]  count_ff;

   logic                          load_rsp;
   logic [usvt_pkg::STATUS_W-1:0] status_c;
   logic [usvt_pkg::SLOT_W-1:0]   found_c;
   logic                          req_xfer;
   logic                          scan_data;

   assign req_tready = (state_ff == usvt_pkg::FSM_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   // read data is valid from the second scan cycle on
   assign scan_data  = (state_ff == usvt_pkg::FSM_SCAN) && (cnt_ff != '0);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, count_ff, found_ff, status_ff};

   // memory ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= usvt_pkg::FSM_CLEAR;
         cnt_ff       <= '0;
         fc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         fc_ff    <= fc_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request capture and result payload
   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_addr;
      if (req_xfer) begin
         action_ff <= req_tuser;
         key_ff    <= req_tdata[31:0];
         nv_ff     <= req_tdata[63:32];
         slot_ff   <= req_tdata[67:64];
      end
      if (load_rsp) begin
         status_ff <= status_c;
         found_ff  <= found_c;
         count_ff  <= usvt_pkg::COUNT_W'(fc_in);
      end
   end

   // scan findings: first key match, any new value match, first empty slot,
   // and whether the addressed slot is occupied
   always_ff @(posedge clock) begin
      if (reset || req_xfer) begin
         key_hit_ff  <= 1'b0;
         nv_hit_ff   <= 1'b0;
         zero_hit_ff <= 1'b0;
         slot_nz_ff  <= 1'b0;
         key_idx_ff  <= '0;
         zero_idx_ff <= '0;
      end else if (scan_data) begin
         if (rd_data_ff == key_ff && !key_hit_ff) begin
            key_hit_ff <= 1'b1;
            key_idx_ff <= rd_idx_ff;
         end
         if (rd_data_ff == nv_ff) begin
            nv_hit_ff <= 1'b1;
         end
         if (rd_data_ff == '0 && !zero_hit_ff) begin
            zero_hit_ff <= 1'b1;
            zero_idx_ff <= rd_idx_ff;
         end
         if (32'(rd_idx_ff) == 32'(slot_ff)) begin
            slot_nz_ff <= (rd_data_ff != '0);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      fc_in    = fc_ff;
      rd_addr  = cnt_ff[AW-1:0];
      mem_we   = 1'b0;
      mem_wa   = '0;
      mem_wd   = '0;
      load_rsp = 1'b0;
      status_c = usvt_pkg::ST_OK;
      found_c  = '0;
      unique case (state_ff)
         usvt_pkg::FSM_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = cnt_ff[AW-1:0];
            if (cnt_ff == CW'(ENTRIES - 1)) begin
               cnt_in   = '0;
               state_in = usvt_pkg::FSM_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         usvt_pkg::FSM_IDLE: begin
            if (req_xfer) begin
               cnt_in   = '0;
               state_in = usvt_pkg::FSM_SCAN;
            end
         end
         usvt_pkg::FSM_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(ENTRIES)) begin
               cnt_in   = '0;
               state_in = usvt_pkg::FSM_DECIDE;
            end
         end
         usvt_pkg::FSM_DECIDE: begin
            unique case (action_ff)
               usvt_pkg::ACT_INSERT: begin
                  if (fc_ff == CW'(ENTRIES)) begin
                     status_c = usvt_pkg::ST_FULL;
                  end else if (key_ff == '0 || key_hit_ff) begin
                     status_c = usvt_pkg::ST_DUP;
                  end else if (!zero_hit_ff) begin
                     status_c = usvt_pkg::ST_FULL;
                  end else begin
                     mem_we = 1'b1;
                     mem_wa = zero_idx_ff;
                     mem_wd = key_ff;
                     fc_in  = fc_ff + 1'b1;
                  end
               end
               usvt_pkg::ACT_REM_VALUE: begin
                  if (fc_ff == '0) begin
                     status_c = usvt_pkg::ST_EMPTY;
                  end else if (key_ff == '0 || !key_hit_ff) begin
                     status_c = usvt_pkg::ST_NOTFOUND;
                  end else begin
                     mem_we = 1'b1;
                     mem_wa = key_idx_ff;
                     fc_in  = fc_ff - 1'b1;
                  end
               end
               usvt_pkg::ACT_REM_SLOT: begin
                  if (fc_ff == '0) begin
                     status_c = usvt_pkg::ST_EMPTY;
                  end else if (32'(slot_ff) >= 32'(ENTRIES)) begin
                     status_c = usvt_pkg::ST_BADSLOT;
                  end else if (slot_nz_ff) begin
                     mem_we = 1'b1;
                     mem_wa = AW'(slot_ff);
                     fc_in  = fc_ff - 1'b1;
                  end
               end
               usvt_pkg::ACT_REPLACE: begin
                  if (fc_ff == '0) begin
                     status_c = usvt_pkg::ST_EMPTY;
                  end else if (nv_ff == '0 || nv_hit_ff) begin
                     status_c = usvt_pkg::ST_DUP;
                  end else if (key_ff == '0 || !key_hit_ff) begin
                     status_c = usvt_pkg::ST_NOTFOUND;
                  end else begin
                     mem_we = 1'b1;
                     mem_wa = key_idx_ff;
                     mem_wd = nv_ff;
                  end
               end
               usvt_pkg::ACT_SEARCH: begin
                  if (fc_ff == '0) begin
                     status_c = usvt_pkg::ST_EMPTY;
                  end else if (key_ff == '0 || !key_hit_ff) begin
                     status_c = usvt_pkg::ST_NOTFOUND;
                  end else begin
                     found_c = usvt_pkg::SLOT_W'(key_idx_ff);
                  end
               end
               default: begin
                  status_c = usvt_pkg::ST_OK;
               end
            endcase
            // hold the outcome until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = usvt_pkg::FSM_IDLE;
            end else begin
               mem_we = 1'b0;
               fc_in  = fc_ff;
            end
         end
         default: begin
            state_in = usvt_pkg::FSM_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      fc_ff <= CW'(ENTRIES))
      else $error("fill count above table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (fc_in != fc_ff) |-> (fc_in == fc_ff + 1'b1 || fc_in == fc_ff - 1'b1))
      else $error("fill count moved by more than one");

   a_no_write_stalled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == usvt_pkg::FSM_DECIDE && rsp_valid_ff && !rsp_tready) |-> !mem_we)
      else $error("memory written while result is stalled");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == usvt_pkg::FSM_CLEAR) |-> !req_tready)
      else $error("request taken during clearing sweep");

   a_load_once: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (state_ff == usvt_pkg::FSM_IDLE && rsp_valid_ff))
      else $error("result load did not return to idle");
`endif

endmodule
